### rtl/assert_macros.svh
// Assertion macros shared by the decompressor RTL.
// No dependencies; NO_ASSERTIONS compiles the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

### rtl/lz77_pkg.sv
// Shared types and constants for the LZ77 bit-stream decompressor.
// No dependencies.
package lz77_pkg;
    localparam logic [1:0] CMD_FEED    = 2'd0;
    localparam logic [1:0] CMD_REQ     = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [2:0] ST_BYTE   = 3'd0;
    localparam logic [2:0] ST_NEED   = 3'd1;
    localparam logic [2:0] ST_END    = 3'd2;
    localparam logic [2:0] ST_BADLEN = 3'd3;
    localparam logic [2:0] ST_BADOFF = 3'd4;
    localparam logic [2:0] ST_OVER   = 3'd5;
    localparam logic [2:0] ST_RUN    = 3'd7;

    localparam logic [24:0] MAX_OUT_RESET = 25'd16777216;
    localparam logic [19:0] END_MARK      = 20'hFFFFF;
    localparam logic [3:0]  LEN_ONES_MAX  = 4'd11;
    localparam logic [3:0]  CLASS_ONES_MAX = 4'd3;

    // queue entry between front and back
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] in_byte;
    } t_cmd;

    function automatic logic [4:0] off_bits(input logic [1:0] c);
        unique case (c)
            2'd0: off_bits = 5'd6;
            2'd1: off_bits = 5'd9;
            2'd2: off_bits = 5'd12;
            default: off_bits = 5'd20;
        endcase
    endfunction

    function automatic logic [12:0] off_bias(input logic [1:0] c);
        unique case (c)
            2'd0: off_bias = 13'd1;
            2'd1: off_bias = 13'd65;
            2'd2: off_bias = 13'd577;
            default: off_bias = 13'd4673;
        endcase
    endfunction
endpackage

### rtl/lz77_bitstream_decompressor.sv
// Top level of the LZ77 bit-stream decompressor: front queue plus back end.
// Depends on lz77_pkg, lz77_front and lz77_back.
// Flow: each transaction is registered in the front queue; feed/restart act when dequeued;
// a request is dequeued and then runs its parse steps (a literal: dequeue, flag, literal; a
// further copied byte: dequeue, history read, write); result registered after.
// Reset (synchronous, active low) clears all parse state; history is not cleared.
module lz77_bitstream_decompressor import lz77_pkg::*; #(
    parameter int HISTORY_DEPTH = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [24:0] i_cfg_data,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [32:8] bytes_out
    output logic [2:0]  m_axis_tuser    // [2:0] status
);
    logic        w_qv, w_pop;
    t_cmd        w_in, w_head;
    logic [24:0] r_max;
    logic [7:0]  w_ob;
    logic [2:0]  w_st;
    logic [24:0] w_cnt;

    assign w_in.cmd     = s_axis_tuser;
    assign w_in.in_byte = s_axis_tdata;
    assign o_cfg_ready  = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max <= MAX_OUT_RESET;
        else if (i_cfg_valid) r_max <= i_cfg_data;
    end

    lz77_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_cmd(w_in), .o_q_valid(w_qv),
        .i_q_pop(w_pop), .o_q_head(w_head)
    );

    lz77_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .o_q_pop(w_pop),
        .i_q_head(w_head), .i_max_out(r_max), .o_res_valid(m_axis_tvalid),
        .i_res_ready(m_axis_tready), .o_out_byte(w_ob), .o_status(w_st),
        .o_bytes_out(w_cnt)
    );

    assign m_axis_tdata = {7'd0, w_cnt, w_ob};
    assign m_axis_tuser = w_st;
endmodule

### rtl/lz77_front.sv
// Front end: accepts stream transactions, drops unknown commands, and
// feeds a two-entry queue to the back end. Depends on lz77_pkg.
`include "assert_macros.svh"
module lz77_front import lz77_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_cmd       i_cmd,
    output logic       o_q_valid,
    input  logic       i_q_pop,
    output t_cmd       o_q_head
);
    logic [1:0] r_cnt, n_cnt;
    t_cmd       r_q [2];
    logic       w_push, w_keep;

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign w_keep    = w_push && (i_cmd.cmd != CMD_UNUSED);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_head  = r_q[0];

    // occupancy
    always_comb begin
        n_cnt = r_cnt + {1'b0, w_keep} - {1'b0, i_q_pop && o_q_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // queue slots; slot 0 is the head
    always_ff @(posedge i_clk) begin
        if (i_q_pop && o_q_valid) begin
            r_q[0] <= (w_keep && r_cnt == 2'd1) ? i_cmd : r_q[1];
            if (w_keep && r_cnt == 2'd2) r_q[1] <= i_cmd;
        end else if (w_keep) begin
            if (r_cnt == 2'd0) r_q[0] <= i_cmd;
            else r_q[1] <= i_cmd;
        end
    end

    `ASSERT_CLK(a_no_overfill, i_clk, i_rst_n, r_cnt != 2'd3, "queue count invalid")
    `ASSERT_CLK(a_full_stall, i_clk, i_rst_n, (r_cnt == 2'd2) |-> !o_ready, "ready while full")
    `ASSERT_CLK(a_pop_nonempty, i_clk, i_rst_n, (i_q_pop && r_cnt == 2'd0 && !w_keep) |=> (r_cnt == 2'd0), "pop from empty")
endmodule

### rtl/lz77_back.sv
// Back end: bit buffer, parse sequencer and history memory; one step per
// cycle while the result register is free. Depends on lz77_pkg.
`include "assert_macros.svh"
module lz77_back import lz77_pkg::*; #(
    parameter int HISTORY_DEPTH = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_pop,
    input  t_cmd        i_q_head,
    input  logic [24:0] i_max_out,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_status,
    output logic [24:0] o_bytes_out
);
    localparam int AW = $clog2(HISTORY_DEPTH);

    localparam logic [3:0] PH_PAD = 4'd0, PH_FLAG = 4'd1, PH_LIT = 4'd2,
        PH_OCLASS = 4'd3, PH_OFFSET = 4'd4, PH_LCOUNT = 4'd5, PH_LGUARD = 4'd6,
        PH_LEXTRA = 4'd7, PH_COPY = 4'd8, PH_CHECK = 4'd9, PH_RD = 4'd10;

    logic [31:0] r_buf, n_buf;
    logic [5:0]  r_held, n_held;
    logic [3:0]  r_ph, n_ph;
    logic [3:0]  r_ones, n_ones;
    logic [20:0] r_dist, n_dist;
    logic [12:0] r_rem, n_rem;
    logic [24:0] r_wpos, n_wpos;
    logic [2:0]  r_fin, n_fin;
    logic        r_busy, n_busy;   // request in progress
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic [2:0]  r_ostat;
    logic [24:0] r_ocnt;
    logic [7:0]  r_hist [HISTORY_DEPTH];
    logic [7:0]  r_rdata;

    logic        w_out_free, w_done, w_emit, w_we, w_rd;
    logic [7:0]  w_ebyte, w_cbyte;
    logic [2:0]  w_stat;
    logic [4:0]  w_nb;
    logic [31:0] w_mask;
    logic [24:0] w_src;

    assign w_out_free = !r_ovalid || i_res_ready;
    assign w_cbyte    = r_rdata;
    assign w_src      = r_wpos - {4'd0, r_dist};

    // parse step
    always_comb begin
        n_buf = r_buf; n_held = r_held; n_ph = r_ph; n_ones = r_ones;
        n_dist = r_dist; n_rem = r_rem; n_wpos = r_wpos; n_fin = r_fin;
        n_busy = r_busy; o_q_pop = 1'b0; w_done = 1'b0; w_stat = ST_NEED;
        w_emit = 1'b0; w_ebyte = 8'd0; w_we = 1'b0; w_rd = 1'b0;
        w_nb = off_bits(r_ones[1:0]);
        w_mask = (32'd1 << w_nb) - 32'd1;
        if (r_busy) begin
            if (w_out_free) begin
                if (r_fin != ST_RUN) begin
                    w_done = 1'b1; w_stat = r_fin;
                end else begin
                    unique case (r_ph)
                        PH_PAD: if (r_held < 6'd8) w_done = 1'b1;
                            else begin
                                n_buf = r_buf >> 8; n_held = r_held - 6'd8; n_ph = PH_FLAG;
                            end
                        PH_FLAG: if (r_held == 6'd0) w_done = 1'b1;
                            else begin
                                n_buf = r_buf >> 1; n_held = r_held - 6'd1;
                                n_ones = 4'd0; n_ph = r_buf[0] ? PH_OCLASS : PH_LIT;
                            end
                        PH_LIT: if (r_held < 6'd8) w_done = 1'b1;
                            else if (r_wpos >= i_max_out) begin
                                n_fin = ST_OVER; w_done = 1'b1; w_stat = ST_OVER;
                            end else begin
                                n_buf = r_buf >> 8; n_held = r_held - 6'd8;
                                w_emit = 1'b1; w_ebyte = r_buf[7:0]; n_ph = PH_FLAG;
                            end
                        PH_OCLASS: if (r_ones >= CLASS_ONES_MAX) n_ph = PH_OFFSET;
                            else if (r_held == 6'd0) w_done = 1'b1;
                            else begin
                                n_buf = r_buf >> 1; n_held = r_held - 6'd1;
                                if (r_buf[0]) n_ones = r_ones + 4'd1;
                                else n_ph = PH_OFFSET;
                            end
                        PH_OFFSET: if (r_held < {1'b0, w_nb}) w_done = 1'b1;
                            else if (r_ones[1:0] == 2'd3 && r_buf[19:0] == END_MARK) begin
                                n_fin = ST_END; w_done = 1'b1; w_stat = ST_END;
                            end else begin
                                n_buf = r_buf >> w_nb; n_held = r_held - {1'b0, w_nb};
                                n_dist = r_buf[20:0] & w_mask[20:0];
                                n_dist = n_dist + {8'd0, off_bias(r_ones[1:0])};
                                n_rem = (r_ones[1:0] == 2'd3) ? 13'd3 : 13'd2;
                                n_ones = 4'd0; n_ph = PH_LCOUNT;
                            end
                        PH_LCOUNT: if (r_ones >= LEN_ONES_MAX) n_ph = PH_LGUARD;
                            else if (r_held == 6'd0) w_done = 1'b1;
                            else begin
                                n_buf = r_buf >> 1; n_held = r_held - 6'd1;
                                if (r_buf[0]) n_ones = r_ones + 4'd1;
                                else n_ph = PH_LEXTRA;
                            end
                        PH_LGUARD: if (r_held == 6'd0) w_done = 1'b1;
                            else if (r_buf[0]) begin
                                n_fin = ST_BADLEN; w_done = 1'b1; w_stat = ST_BADLEN;
                            end else begin
                                n_buf = r_buf >> 1; n_held = r_held - 6'd1; n_ph = PH_LEXTRA;
                            end
                        PH_LEXTRA: if (r_held < {2'd0, r_ones}) w_done = 1'b1;
                            else begin
                                n_buf = r_buf >> r_ones; n_held = r_held - {2'd0, r_ones};
                                n_rem = r_rem + ((13'd1 << r_ones) - 13'd1)
                                    + (r_buf[12:0] & ((13'd1 << r_ones) - 13'd1));
                                n_ph = PH_CHECK;
                            end
                        PH_CHECK: if ({4'd0, r_dist} > r_wpos
                                || 32'(r_dist) > 32'(HISTORY_DEPTH)) begin
                                n_fin = ST_BADOFF; w_done = 1'b1; w_stat = ST_BADOFF;
                            end else n_ph = PH_RD;
                        PH_RD: begin
                            w_rd = 1'b1; n_ph = PH_COPY;
                        end
                        PH_COPY: if (r_wpos >= i_max_out) begin
                                n_fin = ST_OVER; w_done = 1'b1; w_stat = ST_OVER;
                            end else begin
                                w_emit = 1'b1; w_ebyte = w_cbyte;
                                n_rem = r_rem - 13'd1;
                                n_ph = (r_rem == 13'd1) ? PH_FLAG : PH_RD;
                            end
                        default: n_ph = PH_FLAG;
                    endcase
                end
                if (w_emit) begin
                    w_we = 1'b1; n_wpos = r_wpos + 25'd1; w_done = 1'b1; w_stat = ST_BYTE;
                end
                if (w_done) n_busy = 1'b0;
            end
        end else if (i_q_valid) begin
            o_q_pop = 1'b1;
            unique case (i_q_head.cmd)
                CMD_FEED: if (r_held <= 6'd24) begin
                    n_buf = r_buf | ({24'd0, i_q_head.in_byte} << r_held[4:0]);
                    n_held = r_held + 6'd8;
                end
                CMD_RESTART: begin
                    n_buf = 32'd0; n_held = 6'd0; n_ph = PH_PAD; n_ones = 4'd0;
                    n_dist = 21'd0; n_rem = 13'd0; n_wpos = 25'd0; n_fin = ST_RUN;
                end
                CMD_REQ: n_busy = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= 32'd0; r_held <= 6'd0; r_ph <= PH_PAD; r_ones <= 4'd0;
            r_dist <= 21'd0; r_rem <= 13'd0; r_wpos <= 25'd0; r_fin <= ST_RUN;
            r_busy <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_buf <= n_buf; r_held <= n_held; r_ph <= n_ph; r_ones <= n_ones;
            r_dist <= n_dist; r_rem <= n_rem; r_wpos <= n_wpos; r_fin <= n_fin;
            r_busy <= n_busy;
            if (w_done) r_ovalid <= 1'b1;
            else if (i_res_ready) r_ovalid <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_obyte <= (w_stat == ST_BYTE) ? w_ebyte : 8'd0;
            r_ostat <= w_stat;
            r_ocnt  <= n_wpos;
        end
    end

    // history memory; a byte is written in its emit step and the copy source is
    // read in the following PH_RD step, so reads never meet a same-cycle write
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_hist[r_wpos[AW-1:0]] <= w_ebyte;
        end
        if (w_rd) begin
            r_rdata <= r_hist[w_src[AW-1:0]];
        end
    end

    assign o_res_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_status    = r_ostat;
    assign o_bytes_out = r_ocnt;

    `ASSERT_CLK(a_held_range, i_clk, i_rst_n, r_held <= 6'd32, "bit count over 32")
    `ASSERT_CLK(a_no_pop_busy, i_clk, i_rst_n, r_busy |-> !o_q_pop, "pop while busy")
    `ASSERT_CLK(a_emit_count, i_clk, i_rst_n, w_we |=> (r_wpos == $past(r_wpos) + 25'd1), "write position not advanced")
endmodule

### dv/tb.sv
// Self-checking testbench for the LZ77 bit-stream decompressor.
// Depends on lz77_pkg and lz77_bitstream_decompressor (and through it on the rest of rtl/).
// Streams are encoded here, fed and pulled through the stream ports, and every
// output byte, status and byte count is checked against a behavioral decoder that predicts it.
`timescale 1ns / 100ps

module tb;
    import lz77_pkg::*;

    localparam int HIST = 65536;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    typedef enum logic [3:0] {
        P_PAD, P_FLAG, P_LIT, P_OCLASS, P_OFFSET, P_LCOUNT, P_LGUARD, P_LEXTRA, P_COPY
    } t_parse;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] data;
    } t_txn;

    typedef struct {
        logic [7:0]  ob;
        logic [2:0]  st;
        logic [24:0] cnt;
    } t_decoded;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [24:0] i_cfg_data = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    lz77_bitstream_decompressor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // pending transactions and expected decoder answers
    t_txn     pending_txns[$];
    t_decoded expected_bytes[$];
    int       errors = 0;
    int       txns_sent = 0;
    int       results_seen = 0;
    int       streams_run = 0;
    int       idle_cycles = 0;

    // ---------------- behavioral decoder state ----------------
    logic [7:0]  d_hist[HIST];
    logic [31:0] d_buf;
    int unsigned d_held;
    t_parse      d_phase;
    int unsigned d_ones;
    int unsigned d_dist;
    int unsigned d_remain;
    logic [24:0] d_wpos;
    logic [2:0]  d_final;
    logic [24:0] d_max_out;

    function automatic int unsigned class_bits(int unsigned c);
        case (c)
            0: return 6;
            1: return 9;
            2: return 12;
            default: return 20;
        endcase
    endfunction

    function automatic int unsigned class_bias(int unsigned c);
        case (c)
            0: return 1;
            1: return 65;
            2: return 577;
            default: return 4673;
        endcase
    endfunction

    function automatic int unsigned pull_bits(int unsigned n);
        int unsigned v;
        v = d_buf & ((32'd1 << n) - 32'd1);
        d_buf = d_buf >> n;
        d_held -= n;
        return v;
    endfunction

    function automatic void decoder_restart();
        d_buf = '0;
        d_held = 0;
        d_phase = P_PAD;
        d_ones = 0;
        d_dist = 0;
        d_remain = 0;
        d_wpos = '0;
        d_final = ST_RUN;
    endfunction

    // store one byte in history, or flag overflow
    function automatic logic [2:0] put_byte(logic [7:0] b, ref logic [7:0] dst);
        if (d_wpos >= d_max_out) begin
            d_final = ST_OVER;
            return ST_OVER;
        end
        d_hist[d_wpos % HIST] = b;
        d_wpos = d_wpos + 25'd1;
        dst = b;
        return ST_BYTE;
    endfunction

    // run the parser until it answers one request
    function automatic logic [2:0] decoder_advance(ref logic [7:0] dst);
        int unsigned v;
        int unsigned c;
        forever begin
            if (d_final != ST_RUN) return d_final;
            c = d_ones & 3;
            case (d_phase)
                P_PAD: begin
                    if (d_held < 8) return ST_NEED;
                    v = pull_bits(8);
                    d_phase = P_FLAG;
                end
                P_FLAG: begin
                    if (d_held < 1) return ST_NEED;
                    if (pull_bits(1) != 0) begin
                        d_ones = 0;
                        d_phase = P_OCLASS;
                    end else begin
                        d_phase = P_LIT;
                    end
                end
                P_LIT: begin
                    if (d_held < 8) return ST_NEED;
                    v = pull_bits(8);
                    if (put_byte(v[7:0], dst) != ST_BYTE) return ST_OVER;
                    d_phase = P_FLAG;
                    return ST_BYTE;
                end
                P_OCLASS: begin
                    if (d_ones >= 3) begin
                        d_phase = P_OFFSET;
                    end else begin
                        if (d_held < 1) return ST_NEED;
                        if (pull_bits(1) != 0) d_ones++;
                        else d_phase = P_OFFSET;
                    end
                end
                P_OFFSET: begin
                    if (d_held < class_bits(c)) return ST_NEED;
                    v = pull_bits(class_bits(c));
                    if (c == 3 && v == END_MARK) begin
                        d_final = ST_END;
                        return ST_END;
                    end
                    d_dist = v + class_bias(c);
                    d_remain = (c == 3) ? 3 : 2;
                    d_ones = 0;
                    d_phase = P_LCOUNT;
                end
                P_LCOUNT: begin
                    if (d_ones >= LEN_ONES_MAX) begin
                        d_phase = P_LGUARD;
                    end else begin
                        if (d_held < 1) return ST_NEED;
                        if (pull_bits(1) != 0) d_ones++;
                        else d_phase = P_LEXTRA;
                    end
                end
                P_LGUARD: begin
                    if (d_held < 1) return ST_NEED;
                    if (pull_bits(1) != 0) begin
                        d_final = ST_BADLEN;
                        return ST_BADLEN;
                    end
                    d_phase = P_LEXTRA;
                end
                P_LEXTRA: begin
                    if (d_ones != 0) begin
                        if (d_held < d_ones) return ST_NEED;
                        v = pull_bits(d_ones);
                        d_remain += ((1 << d_ones) - 1) + v;
                    end
                    if (d_dist > d_wpos || d_dist > HIST) begin
                        d_final = ST_BADOFF;
                        return ST_BADOFF;
                    end
                    d_phase = P_COPY;
                end
                P_COPY: begin
                    if (d_remain == 0) begin
                        d_phase = P_FLAG;
                    end else begin
                        v = (d_wpos - d_dist) % HIST;
                        if (put_byte(d_hist[v], dst) != ST_BYTE) return ST_OVER;
                        d_remain--;
                        if (d_remain == 0) d_phase = P_FLAG;
                        return ST_BYTE;
                    end
                end
                default: d_phase = P_FLAG;
            endcase
        end
    endfunction

    // queue one transaction and work out its answer, if any
    function automatic logic [2:0] put_txn(logic [1:0] cmd, logic [7:0] data);
        t_txn     t;
        t_decoded r;
        logic [7:0] b;
        t.cmd = cmd;
        t.data = data;
        pending_txns.insert(pending_txns.size(), t);
        b = '0;
        case (cmd)
            CMD_FEED: begin
                if (d_held <= 24) begin
                    d_buf = d_buf | (32'(data) << d_held);
                    d_held += 8;
                end
                return ST_RUN;
            end
            CMD_RESTART: begin
                decoder_restart();
                return ST_RUN;
            end
            CMD_REQ: begin
                r.st = decoder_advance(b);
                r.ob = (r.st == ST_BYTE) ? b : 8'd0;
                r.cnt = d_wpos;
                expected_bytes.insert(expected_bytes.size(), r);
                return r.st;
            end
            default: return ST_RUN;
        endcase
    endfunction

    // ---------------- stream encoder ----------------
    bit stream_bits[$];

    function automatic void add_bits(int unsigned v, int unsigned n);
        for (int i = 0; i < n; i++) stream_bits.insert(stream_bits.size(), v[i]);
    endfunction

    // kind: 0 end marker, 1 bad length guard, 2 bad offset, 3 truncated
    function automatic void encode_stream(int ntok, int kind, int max_prefix);
        int unsigned made;
        int unsigned c;
        int unsigned span;
        int unsigned n;
        stream_bits.delete();
        made = 0;
        add_bits($urandom, 8);
        for (int k = 0; k < ntok; k++) begin
            if (made == 0 || $urandom_range(0, 2) == 0) begin
                add_bits(0, 1);
                add_bits($urandom, 8);
                made++;
            end else begin
                c = $urandom_range(0, 3);
                while (class_bias(c) > made) c--;
                add_bits(1, 1);
                add_bits((1 << c) - 1, c);
                if (c < 3) add_bits(0, 1);
                span = ((made < HIST) ? made : HIST) - class_bias(c);
                if (span > (1 << class_bits(c)) - 1) span = (1 << class_bits(c)) - 1;
                add_bits($urandom_range(0, span), class_bits(c));
                n = $urandom_range(0, max_prefix);
                add_bits((1 << n) - 1, n);
                add_bits(0, 1);
                add_bits($urandom, n);
                made += ((c == 3) ? 3 : 2) + (1 << n) - 1 + 0;
            end
        end
        case (kind)
            0: begin
                add_bits(1, 1);
                add_bits(7, 3);
                add_bits(END_MARK, 20);
            end
            1: begin
                add_bits(1, 1);
                add_bits(0, 1);
                add_bits(0, 6);
                add_bits(11'h7FF, 11);
                add_bits(1, 1);
            end
            2: begin
                add_bits(1, 1);
                if (made < 64) begin
                    add_bits(0, 1);
                    add_bits(made, 6);
                end else begin
                    add_bits(7, 3);
                    add_bits($urandom_range(HIST, 20'hFFFFE), 20);
                end
                add_bits(0, 1);
            end
            default: ;
        endcase
        while (stream_bits.size() % 8 != 0) add_bits($urandom_range(0, 1), 1);
    endfunction

    // feed the encoded stream and pull bytes until it stops
    function automatic void play_stream(bit noisy);
        logic [7:0] b;
        logic [2:0] st;
        streams_run++;
        void'(put_txn(CMD_RESTART, $urandom));
        forever begin
            if (noisy && $urandom_range(0, 15) == 0)
                void'(put_txn(CMD_UNUSED, $urandom));
            if (noisy && $urandom_range(0, 31) == 0)
                void'(put_txn(CMD_FEED, $urandom));
            // feed, three times in four, while bytes remain and the decoder still accepts a byte
            if (stream_bits.size() >= 8 && d_held <= 24 && $urandom_range(0, 3) != 0) begin
                for (int i = 0; i < 8; i++) b[i] = stream_bits.pop_front();
                void'(put_txn(CMD_FEED, b));
            end else begin
                st = put_txn(CMD_REQ, $urandom);
                if (st != ST_BYTE && st != ST_NEED) begin
                    repeat ($urandom_range(1, 2)) void'(put_txn(CMD_REQ, $urandom));
                    return;
                end
                if (st == ST_NEED && stream_bits.size() == 0) return;
            end
        end
    endfunction

    // ---------------- sender ----------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        t_txn t;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) txns_sent++;
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_txns.size() > 0) begin
                t = pending_txns.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= t.data;
                s_axis_tuser <= t.cmd;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                burst_left--;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- receiver stall pattern ----------------
    int unsigned rx_cycle = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            rx_cycle++;
            case ((rx_cycle / 300) % 3)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_decoded want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected result, actual %h/%h", $time, m_axis_tdata,
                         m_axis_tuser);
                errors++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_axis_tdata[7:0] !== want.ob) begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.ob, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tuser !== want.st) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.st, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[32:8] !== want.cnt) begin
                    $display("%0t: bytes_out expected %0d actual %0d",
                             $time, want.cnt, m_axis_tdata[32:8]);
                    errors++;
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d answers outstanding",
                     $time, expected_bytes.size());
            $display("FAIL");
            $finish;
        end
    end

    // wait until every queued transaction is answered
    task automatic drain();
        while (pending_txns.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write the size limit while the block is idle
    task automatic write_limit(logic [24:0] value);
        drain();
        d_max_out = value;
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------- stimulus ----------------
    initial begin
        logic [24:0] lim;
        foreach (d_hist[i]) d_hist[i] = '0;
        d_max_out = MAX_OUT_RESET;
        decoder_restart();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle requests, unknown command, overfilled buffer
        void'(put_txn(CMD_REQ, 8'h00));
        void'(put_txn(CMD_UNUSED, 8'hFF));
        void'(put_txn(CMD_FEED, 8'hFF));
        void'(put_txn(CMD_FEED, 8'h00));
        void'(put_txn(CMD_FEED, 8'hFE));
        void'(put_txn(CMD_FEED, 8'h01));
        void'(put_txn(CMD_FEED, 8'hAA));
        repeat (3) void'(put_txn(CMD_REQ, 8'hFF));
        // each end kind of the encoder: end marker, bad length, bad offset, truncated
        for (int k = 0; k < 4; k++) begin
            encode_stream(3, k, 2);
            play_stream(1'b0);
        end
        // one byte allowed: second byte overflows
        write_limit(25'd1);
        encode_stream(4, 0, 1);
        play_stream(1'b0);
        write_limit(25'd16777215);
        encode_stream(4, 0, 1);
        play_stream(1'b0);
        drain();

        // random streams; limits change between groups
        while (txns_sent < 750) begin
            for (int g = 0; g < 2; g++) begin
                encode_stream($urandom_range(3, 12),
                              ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3),
                              ($urandom_range(0, 7) == 0) ? 6 : 3);
                play_stream(1'b1);
            end
            case ($urandom_range(0, 3))
                0: lim = $urandom_range(1, 40);
                1: lim = 25'd1;
                2: lim = 25'd16777216;
                default: lim = $urandom_range(2, 16777215);
            endcase
            write_limit(lim);
        end
        write_limit(MAX_OUT_RESET);
        encode_stream(6, 0, 3);
        play_stream(1'b1);
        drain();

        $display("Ran %0d streams: %0d transactions in, %0d answers checked, %0d errors.",
                 streams_run, txns_sent, results_seen, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

### lz77_bitstream_decompressor.f
+incdir+rtl
rtl/lz77_pkg.sv
rtl/lz77_front.sv
rtl/lz77_back.sv
rtl/lz77_bitstream_decompressor.sv
dv/tb.sv
